// ===== sv/fpbm_pkg.sv =====
// Shared constants and types for the fixed pattern byte matcher.
`timescale 1ns / 1ps

package fpbm_pkg;

  // Default pattern capacity in bytes (legal range 1 to 32).
  localparam int PATTERN_MAX_DEF = 32;

  // Pattern storage is always four 64-bit registers, 32 bytes.
  localparam int PAT_REGS   = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;
  localparam int BYTE_W     = 8;

  localparam int LEN_W      = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  localparam int POS_W      = 31;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [PAT_BYTES-1:0] pattern_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH      = 3'd0,
    REG_BYTES_0_7   = 3'd1,
    REG_BYTES_8_15  = 3'd2,
    REG_BYTES_16_23 = 3'd3,
    REG_BYTES_24_31 = 3'd4
  } cfg_reg_t;

endpackage

// ===== sv/fixed_pattern_byte_matcher.sv =====
// Top level of the fixed pattern byte matcher: window, position counter, output queue.
`timescale 1ns / 1ps

// Streaming byte matcher. Each input word carries one text byte; tuser marks
// the first byte of a new text, which restarts the position count at zero.
// Every byte is compared in parallel against the whole configured pattern
// (1 to PATTERN_MAX bytes), so one word is taken per clock while s_tready is
// high; a match is queued as the byte completing it is taken. Each result word
// carries the 0-based start position of the occurrence; overlapping matches
// are all reported, in ascending order. The position saturates at 2^31-1.
// The output side has a two-entry queue (output register plus skid), so the
// input keeps flowing while one result waits; s_tready drops only when both
// entries are full. Configure pattern_length (index 0) and the four 64-bit
// pattern byte registers (indexes 1 to 4, byte i in bits 8i+7:8i) while the
// stream is idle; a length of 0 acts as 1 and one above PATTERN_MAX acts as
// PATTERN_MAX.

module fixed_pattern_byte_matcher #(
  parameter int PATTERN_MAX = fpbm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [fpbm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fpbm_pkg::CFG_W-1:0]             cfg_data,
  // text input
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [fpbm_pkg::IN_TDATA_W-1:0]        s_tdata,   // [7:0] text_byte
  input  logic                                   s_tuser,   // [0] first_of_text
  // match output
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fpbm_pkg::OUT_TDATA_W-1:0]       m_tdata    // [30:0] match_start, [31] zero
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [fpbm_pkg::LEN_W-1:0]  len_raw;
  logic [fpbm_pkg::CFG_W-1:0]  pattern_regs [fpbm_pkg::PAT_REGS];
  fpbm_pkg::pattern_t          pattern_bytes;
  logic [fpbm_pkg::LEN_W-1:0]  len_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_raw <= fpbm_pkg::LEN_W'(1);
      for (int r = 0; r < fpbm_pkg::PAT_REGS; r++) begin
        pattern_regs[r] <= '0;
      end
    end else if (cfg_we) begin
      case (fpbm_pkg::cfg_reg_t'(cfg_index))
        fpbm_pkg::REG_LENGTH:      len_raw         <= cfg_data[fpbm_pkg::LEN_W-1:0];
        fpbm_pkg::REG_BYTES_0_7:   pattern_regs[0] <= cfg_data;
        fpbm_pkg::REG_BYTES_8_15:  pattern_regs[1] <= cfg_data;
        fpbm_pkg::REG_BYTES_16_23: pattern_regs[2] <= cfg_data;
        fpbm_pkg::REG_BYTES_24_31: pattern_regs[3] <= cfg_data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Unpack the pattern registers into a byte array, byte i in register i/8.
  always_comb begin
    for (int r = 0; r < fpbm_pkg::PAT_REGS; r++) begin
      for (int k = 0; k < fpbm_pkg::CFG_W / fpbm_pkg::BYTE_W; k++) begin
        pattern_bytes[r * (fpbm_pkg::CFG_W / fpbm_pkg::BYTE_W) + k] =
          pattern_regs[r][k * fpbm_pkg::BYTE_W +: fpbm_pkg::BYTE_W];
      end
    end
  end

  // Clamp the length into 1..PATTERN_MAX.
  always_comb begin
    if (len_raw == '0) begin
      len_used = fpbm_pkg::LEN_W'(1);
    end else if (len_raw > fpbm_pkg::LEN_W'(PATTERN_MAX)) begin
      len_used = fpbm_pkg::LEN_W'(PATTERN_MAX);
    end else begin
      len_used = len_raw;
    end
  end

  // ---------------------------------------------------------------------
  // Input side: window shift register and position counter
  // ---------------------------------------------------------------------
  logic                              s_accept;
  logic                              s_first;
  fpbm_pkg::byte_t                   s_byte;
  fpbm_pkg::byte_t [PATTERN_MAX-1:0] window;
  fpbm_pkg::byte_t [PATTERN_MAX-1:0] window_next;
  logic [fpbm_pkg::POS_W-1:0]        position;
  logic [fpbm_pkg::POS_W-1:0]        pos_cur;
  logic [fpbm_pkg::POS_W-1:0]        position_next;

  assign s_accept = s_tvalid && s_tready;
  assign s_first  = s_tuser;
  assign s_byte   = s_tdata[fpbm_pkg::BYTE_W-1:0];

  // Entry 0 takes the newest byte; stale entries from an earlier text are
  // harmless because no match is reported before len bytes of this text.
  always_comb begin
    window_next[0] = s_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
  end

  // Position of the byte being taken in; a new text restarts at zero.
  assign pos_cur       = s_first ? '0 : position;
  assign position_next = (pos_cur == fpbm_pkg::POS_MAX) ? fpbm_pkg::POS_MAX
                                                        : pos_cur + fpbm_pkg::POS_W'(1);

  always_ff @(posedge clk) begin
    if (s_accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (s_accept) begin
      position <= position_next;
    end
  end

  // ---------------------------------------------------------------------
  // Match detection
  // ---------------------------------------------------------------------
  logic                         all_equal;
  logic                         long_enough;
  logic                         hit;
  logic [fpbm_pkg::POS_W:0]     count_in;
  logic [fpbm_pkg::POS_W-1:0]   start_pos;

  fpbm_window_cmp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cmp (
    .window        (window_next),
    .pattern_bytes (pattern_bytes),
    .len_used      (len_used),
    .all_equal     (all_equal)
  );

  // Bytes of this text held after this one goes in.
  assign count_in    = {1'b0, pos_cur} + (fpbm_pkg::POS_W + 1)'(1);
  assign long_enough = count_in >= (fpbm_pkg::POS_W + 1)'(len_used);
  assign hit         = all_equal && long_enough;
  assign start_pos   = fpbm_pkg::POS_W'(count_in - (fpbm_pkg::POS_W + 1)'(len_used));

  // ---------------------------------------------------------------------
  // Output queue: main register drives the port, skid absorbs one more
  // ---------------------------------------------------------------------
  logic                         push;
  logic                         pop;
  logic                         main_valid;
  logic [fpbm_pkg::POS_W-1:0]   main_pos;
  logic                         skid_valid;
  logic [fpbm_pkg::POS_W-1:0]   skid_pos;

  assign s_tready = !skid_valid;
  assign push     = s_accept && hit;
  assign pop      = main_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        // advance the skid word; no push can arrive while the skid is full
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_pos <= skid_valid ? skid_pos : start_pos;
    end else if (push && !main_valid) begin
      main_pos <= start_pos;
    end
    if (push && main_valid && !pop) begin
      skid_pos <= start_pos;
    end
  end

  assign m_tvalid = main_valid;
  assign m_tdata  = {1'b0, main_pos};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_needs_main: assert property (
    @(posedge clk) disable iff (rst) skid_valid |-> main_valid
  ) else $error("skid entry held while output register is empty");

  a_hit_reaches_output: assert property (
    @(posedge clk) disable iff (rst) push |=> main_valid
  ) else $error("match was dropped on the way to the output");

  a_skid_drains: assert property (
    @(posedge clk) disable iff (rst) (pop && skid_valid) |=> (main_valid && !skid_valid)
  ) else $error("skid word not moved into the output register");

  a_position_counts: assert property (
    @(posedge clk) disable iff (rst)
      (s_accept && !s_first && position != fpbm_pkg::POS_MAX)
      |=> position == $past(position) + fpbm_pkg::POS_W'(1)
  ) else $error("position counter did not advance by one");

endmodule

// ===== sv/fpbm_window_cmp.sv =====
// Parallel compare of the text window against the pattern, one byte lane per window entry.
`timescale 1ns / 1ps

module fpbm_window_cmp #(
  parameter int PATTERN_MAX = fpbm_pkg::PATTERN_MAX_DEF
) (
  input  fpbm_pkg::byte_t [PATTERN_MAX-1:0]  window,
  input  fpbm_pkg::pattern_t                 pattern_bytes,
  input  logic [fpbm_pkg::LEN_W-1:0]         len_used,
  output logic                               all_equal
);

  logic [PATTERN_MAX-1:0] lane_ok;

  // Window entry j is the byte len-1-j places from the pattern start.
  always_comb begin
    logic [fpbm_pkg::LEN_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = fpbm_pkg::LEN_W'(len_used - fpbm_pkg::LEN_W'(1) - fpbm_pkg::LEN_W'(j));
      if (fpbm_pkg::LEN_W'(j) < len_used) begin
        lane_ok[j] = (window[j] == pattern_bytes[idx[fpbm_pkg::PAT_IDX_W-1:0]]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign all_equal = &lane_ok;

endmodule

// ===== tb/fixed_pattern_byte_matcher_tb.sv =====
// Self-checking testbench for the fixed pattern byte matcher: directed and random text streams.
`timescale 1ns / 1ps

// Drive text bytes into the matcher with random gaps on the input side and
// random back-pressure on the output side. Predict every match start with a
// software window compare and check each result word in order. Reprogram the
// pattern only once the block has gone quiet. Finish with a pass or fail line.
module fixed_pattern_byte_matcher_tb;
  import fpbm_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 8;      // result latency plus the two-entry output queue
  localparam int WATCHDOG_CYCLES = 2000;   // cycles with no handshake and no write
  localparam int ITEM_TOTAL      = 1360;
  localparam int CALM_AFTER      = 1160;   // no idling on either side past this many bytes
  localparam int CFG_IDX_LAST    = (1 << CFG_IDX_W) - 1;

  // Software copy of the matcher: registers, window and position, plus the
  // queue of match starts still owed by the block.
  class match_scoreboard;
    logic [LEN_W-1:0] length_reg;
    logic [CFG_W-1:0] pattern_reg [PAT_REGS];
    byte_t            window [PAT_BYTES];   // entry 0 holds the newest byte
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] starts_due [$];
    int               fails;

    function new();
      length_reg = LEN_W'(1);
      foreach (pattern_reg[i]) pattern_reg[i] = '0;
      foreach (window[i]) window[i] = '0;
      next_pos = '0;
      fails = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_LENGTH) begin
        length_reg = value[LEN_W-1:0];
      end else if (idx <= REG_BYTES_24_31) begin
        pattern_reg[idx - 1] = value;
      end
      // indexes past the last register are dropped
    endfunction

    // Take in one accepted byte and queue the match start it completes, if any.
    function void take_byte(byte_t b, logic first);
      int len;
      logic [POS_W-1:0] here;
      bit hit;
      len = length_reg;
      if (len < 1) len = 1;
      if (len > PAT_BYTES) len = PAT_BYTES;
      if (first) begin
        foreach (window[i]) window[i] = '0;
        next_pos = '0;
      end
      for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      here = next_pos;
      if (next_pos != POS_MAX) next_pos = next_pos + 1'b1;
      // bytes from before the start of the text never count
      hit = (longint'(here) + 1) >= len;
      for (int i = 0; hit && i < len; i++) begin
        if (pattern_reg[i / 8][(i % 8) * 8 +: 8] != window[len - 1 - i]) hit = 0;
      end
      if (hit) starts_due = {starts_due, POS_W'(longint'(here) + 1 - len)};
    endfunction

    function void check_match(logic [OUT_TDATA_W-1:0] word);
      logic [POS_W-1:0] want;
      if (starts_due.size() == 0) begin
        $error("match_start: expected none, actual %0d", word[POS_W-1:0]);
        fails++;
      end else begin
        want = starts_due.pop_front();
        if (word[POS_W-1:0] != want) begin
          $error("match_start: expected %0d, actual %0d", want, word[POS_W-1:0]);
          fails++;
        end
      end
      if (word[OUT_TDATA_W-1:POS_W] != '0) begin
        $error("m_tdata pad: expected 0, actual %0d", word[OUT_TDATA_W-1:POS_W]);
        fails++;
      end
    endfunction

    function int pending();
      return starts_due.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata;    // [7:0] text_byte
  logic                    s_tuser;    // [0] first_of_text
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;    // [30:0] match_start, [31] zero

  match_scoreboard sb;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  text_restart = 0;   // next byte opens a new text
  bit  steady_phase = 0;   // no input gaps in this phase
  bit  calm;

  assign calm = (items_sent >= CALM_AFTER);

  fixed_pattern_byte_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output back-pressure: drop tready in bursts of random length, none near the end.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      m_tready = 1'b1;
    end
  end

  // Check every result word the moment it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_match(m_tdata);
  end

  // Count cycles in which nothing moves; any word, write or reset clears it.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_CYCLES);
    $display("fixed_pattern_byte_matcher_tb failed");
    $finish;
  end

  // Present one text byte and hold it until the block takes the word. Hold
  // tvalid high between back-to-back bytes; insert a gap only now and then.
  task automatic send_byte(byte_t b);
    @(negedge clk);
    if (!calm && !steady_phase && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = text_restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_byte(b, text_restart);
    text_restart = 0;
    items_sent++;
  endtask

  // Registers change only while the block is idle, so the model takes the
  // write at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop the input, wait for every owed result, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: program a pattern, then stream texts built mostly from
  // whole copies, broken copies and prefixes of it, with noise in between.
  task automatic run_phase();
    int code;
    int eff;
    int mode;
    int unit_len;
    int budget;
    int start_count;
    int seg;
    int cut;
    byte_t pat [PAT_BYTES];
    byte_t unit [3];
    logic [CFG_W-1:0] pat_word [PAT_REGS];
    logic [CFG_W-1:0] len_word;
    case ($urandom_range(0, 15))
      0:       code = 0;                        // acts as 1
      1:       code = PAT_BYTES;
      2:       code = $urandom_range(PAT_BYTES + 1, 62);
      3:       code = (1 << LEN_W) - 1;
      4, 5, 6: code = $urandom_range(9, PAT_BYTES - 1);
      default: code = $urandom_range(1, 8);
    endcase
    eff = (code < 1) ? 1 : (code > PAT_BYTES) ? PAT_BYTES : code;

    // random, periodic (overlapping matches) or two-letter patterns
    mode = $urandom_range(0, 2);
    unit_len = $urandom_range(1, 3);
    foreach (unit[i]) unit[i] = byte_t'($urandom);
    for (int i = 0; i < PAT_BYTES; i++) begin
      case (mode)
        0:       pat[i] = byte_t'($urandom);
        1:       pat[i] = unit[i % unit_len];
        default: pat[i] = unit[$urandom_range(0, 1)];
      endcase
      pat_word[i / 8][(i % 8) * 8 +: 8] = pat[i];
    end

    // upper bits of the length write are junk the block must mask off
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(code);
    write_reg(REG_LENGTH, len_word);
    for (int r = 0; r < PAT_REGS; r++) write_reg(CFG_IDX_W'(REG_BYTES_0_7 + r), pat_word[r]);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_BYTES_24_31 + 1, CFG_IDX_LAST)), {$urandom, $urandom});
    end

    steady_phase = ($urandom_range(0, 3) == 0);
    text_restart = $urandom_range(0, 1);
    budget = $urandom_range(40, 90) + 3 * eff;
    start_count = items_sent;
    while (items_sent - start_count < budget && items_sent < ITEM_TOTAL) begin
      seg = $urandom_range(0, 9);
      case (seg)
        0: text_restart = 1;
        1, 2, 3, 4: begin
          for (int k = 0; k < eff; k++) send_byte(pat[k]);
        end
        5: begin
          // one byte off: must not match
          cut = $urandom_range(0, eff - 1);
          for (int k = 0; k < eff; k++) begin
            send_byte((k == cut) ? pat[k] ^ byte_t'($urandom_range(1, 255)) : pat[k]);
          end
        end
        6: begin
          cut = $urandom_range(1, eff);
          for (int k = 0; k < cut; k++) send_byte(pat[k]);
        end
        default: begin
          cut = $urandom_range(1, 6);
          for (int k = 0; k < cut; k++) begin
            send_byte($urandom_range(0, 1) ? pat[$urandom_range(0, eff - 1)] : byte_t'($urandom));
          end
        end
      endcase
    end
    settle();
    steady_phase = 0;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset pattern is one zero byte; the first text counts from 0 without
    // the first-of-text flag.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    text_restart = 1;
    send_byte(8'h00);
    settle();

    // Length 0 acts as 1. Writes past the last index must not disturb byte 0.
    write_reg(REG_LENGTH, '0);
    write_reg(REG_BYTES_0_7, 64'hFF);
    for (int idx = REG_BYTES_24_31 + 1; idx <= CFG_IDX_LAST; idx++) write_reg(CFG_IDX_W'(idx), '0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    // Pattern 00 00 5A: the window left from the earlier text must not
    // complete it on the first byte of a text.
    write_reg(REG_LENGTH, 64'd3);
    write_reg(REG_BYTES_0_7, 64'h5A_0000);
    text_restart = 1;
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h5A);
    settle();

    // Reprogram mid-text: the window carries over into the new pattern.
    write_reg(REG_LENGTH, 64'd2);
    write_reg(REG_BYTES_0_7, 64'h815A);
    send_byte(8'h81);
    settle();

    while (items_sent < ITEM_TOTAL) run_phase();
    settle();

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("fixed_pattern_byte_matcher_tb passed");
    end else begin
      $display("fixed_pattern_byte_matcher_tb failed");
    end
    $finish;
  end

endmodule
